// ===== rtl/mmsn_pkg.sv =====
// Shared constants and types for the min-max sample normalizer.
// No dependencies; compile first.
package mmsn_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_W    = 16;
  localparam int NORM_W      = 17;
  localparam int ADDR_W      = $clog2(MAX_SAMPLES);
  localparam int COUNT_W     = $clog2(MAX_SAMPLES + 1);
  localparam int DIV_STEPS   = NORM_W;
  localparam int STEP_W      = $clog2(DIV_STEPS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV,
    S_PUT
  } state_t;

endpackage

// ===== rtl/mmsn_if.sv =====
// Request channels for the min-max sample normalizer: samples in, results out.
// Depends on mmsn_pkg.
interface mmsn_in_if
  import mmsn_pkg::*;
();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       last_sample;

  modport source(output valid, sample, last_sample, input ready);
  modport sink(input valid, sample, last_sample, output ready);
endinterface

interface mmsn_out_if
  import mmsn_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [NORM_W-1:0] normalized;
  logic              last_result;
  logic              overflowed;

  modport source(output valid, normalized, last_result, overflowed, input ready);
  modport sink(input valid, normalized, last_result, overflowed, output ready);
endinterface

// ===== rtl/min_max_sample_normalizer.sv =====
// Min-max sample normalizer top level: sample store, running extremes,
// shared restoring divider and output register. Depends on mmsn_pkg, mmsn_if.
//
// Usage:
//   samples: one signed 16-bit sample per request; last_sample ends the set.
//   results: one request per stored sample, in arrival order, carrying
//     (x - min) / (max - min) as unsigned Q1.16, truncated toward zero.
//   Samples are loaded while the block is idle. Up to MAX_SAMPLES samples are kept;
//   later ones are dropped and flag every result of the set as overflowed.
//   After the ending sample, the block reads the store one entry at a time
//   and runs a 17-step restoring divider, one quotient bit per cycle, for
//   each entry. The store read for the next entry happens in the same cycle
//   as the output load of the current result. samples.ready is low from
//   the ending sample until the last result is loaded into the output
//   register. A flat set (max equals min) gives zeros.
//   A stalled receiver holds the output register; the divider waits for the
//   register to free before loading the next result.
//   Reset (rst, synchronous) empties the set and drops any pending result.
module min_max_sample_normalizer
  import mmsn_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  mmsn_in_if.sink    samples,
  mmsn_out_if.source results
);

  logic signed [SAMPLE_W-1:0] mem [MAX_SAMPLES];

  state_t                     state;
  state_t                     state_next;
  logic [COUNT_W-1:0]         count;
  logic signed [SAMPLE_W-1:0] min_val;
  logic signed [SAMPLE_W-1:0] max_val;
  logic                       ovf;
  logic [ADDR_W-1:0]          idx;
  logic signed [SAMPLE_W-1:0] rd_data;
  logic [SAMPLE_W-1:0]        range_val;
  logic [SAMPLE_W-1:0]        rem;
  logic [NORM_W-1:0]          quo;
  logic [STEP_W-1:0]          step;
  logic                       out_valid;

  logic                       accept;
  logic                       slot_free;
  logic                       is_last;
  logic                       load_out;
  logic                       rd_next;
  logic [ADDR_W-1:0]          rd_addr;
  logic [NORM_W-1:0]          diff;
  logic [NORM_W-1:0]          trial;
  logic                       ge;
  logic [NORM_W-1:0]          sub;
  logic [NORM_W-1:0]          range_ext;

  assign accept    = samples.valid && samples.ready;
  assign slot_free = !out_valid || results.ready;
  assign is_last   = ({1'b0, idx} == count - COUNT_W'(1));

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && samples.last_sample) state_next = S_READ;
      end
      S_READ: state_next = S_DIV;
      S_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = S_PUT;
      end
      S_PUT: begin
        if (slot_free) state_next = is_last ? S_IDLE : S_DIV;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    samples.ready = (state == S_IDLE);
    load_out      = (state == S_PUT) && slot_free;
    rd_next       = (state == S_PUT);
  end

  assign rd_addr = rd_next ? idx + ADDR_W'(1) : idx;

  // divider datapath: one restoring step per cycle
  assign diff      = NORM_W'({rd_data[SAMPLE_W-1], rd_data} - {min_val[SAMPLE_W-1], min_val});
  assign range_ext = {1'b0, range_val};
  assign trial     = (step == '0) ? diff : {rem, 1'b0};
  assign ge        = (trial >= range_ext);
  assign sub       = trial - range_ext;

  always_ff @(posedge clk) begin
    if (accept && (count < COUNT_W'(MAX_SAMPLES))) mem[count[ADDR_W-1:0]] <= samples.sample;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      min_val <= '0;
      max_val <= '0;
      ovf     <= 1'b0;
      idx     <= '0;
      step    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (count < COUNT_W'(MAX_SAMPLES)) begin
              count <= count + COUNT_W'(1);
              if (count == '0) begin
                min_val <= samples.sample;
                max_val <= samples.sample;
              end else begin
                if (samples.sample < min_val) min_val <= samples.sample;
                if (samples.sample > max_val) max_val <= samples.sample;
              end
            end else begin
              ovf <= 1'b1;
            end
            idx  <= '0;
            step <= '0;
          end
        end
        S_DIV: begin
          step <= (step == STEP_W'(DIV_STEPS - 1)) ? '0 : step + STEP_W'(1);
        end
        S_PUT: begin
          if (slot_free) begin
            if (is_last) begin
              count   <= '0;
              min_val <= '0;
              max_val <= '0;
              ovf     <= 1'b0;
            end else begin
              idx <= idx + ADDR_W'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) range_val <= SAMPLE_W'(max_val - min_val);
    if (state == S_DIV) begin
      rem <= SAMPLE_W'(ge ? sub : trial);
      quo <= {quo[NORM_W-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      results.normalized  <= (range_val == '0) ? '0 : quo;
      results.last_result <= is_last;
      results.overflowed  <= ovf;
    end
  end

  assign results.valid = out_valid;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= COUNT_W'(MAX_SAMPLES))
    else $error("stored count beyond capacity");

  a_busy_has_samples: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (count != '0))
    else $error("emitting with an empty set");

  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    (count != '0) |-> (min_val <= max_val))
    else $error("running minimum above maximum");

  a_quotient_bound: assert property (@(posedge clk) disable iff (rst)
    load_out |-> (quo <= NORM_W'(1 << (NORM_W - 1))) || (range_val == '0))
    else $error("quotient above 1.0");

endmodule
